// File: src/avt_pkg.sv
package avt_pkg;

	typedef enum logic [1:0] {
		KIND_VERTEX,
		KIND_TICK,
		KIND_VIEW,
		KIND_PLACE
	} avt_kind_t;

	localparam logic [2:0] CFG_SCALE_X = 3'd0;
	localparam logic [2:0] CFG_SCALE_Y = 3'd1;
	localparam logic [2:0] CFG_COS     = 3'd2;
	localparam logic [2:0] CFG_SIN     = 3'd3;
	localparam logic [2:0] CFG_STEP_X  = 3'd4;
	localparam logic [2:0] CFG_STEP_Y  = 3'd5;
	localparam logic [2:0] CFG_LIMIT_X = 3'd6;

	localparam logic signed [15:0] RST_SCALE = 16'sd256;
	localparam logic signed [15:0] RST_COS   = 16'sd16384;
	localparam logic signed [15:0] RST_SIN   = 16'sd0;
	localparam logic [31:0]        RST_STEP_X = 32'd65536;
	localparam logic [31:0]        RST_STEP_Y = 32'd0;
	localparam logic [30:0]        RST_LIMIT_X = 31'd41943040;
	localparam logic [31:0]        Q_ONE = 32'd65536;

	localparam int              VIEW_WORDS = 6;
	localparam logic [2:0]      VW_A00 = 3'd0;
	localparam logic [2:0]      VW_A01 = 3'd1;
	localparam logic [2:0]      VW_A10 = 3'd2;
	localparam logic [2:0]      VW_A11 = 3'd3;
	localparam logic [2:0]      VW_TX  = 3'd4;
	localparam logic [2:0]      VW_TY  = 3'd5;

	localparam int VTX_STEPS = 17;
	localparam int STEP_W    = $clog2(VTX_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VTX,
		ST_TICK_REV,
		ST_TICK_ADD,
		ST_DONE
	} avt_state_t;

	typedef enum logic [1:0] {MA_IN_X, MA_IN_Y, MA_UX, MA_UY} mul_a_t;
	typedef enum logic [2:0] {
		MB_SCX, MB_SCY, MB_COS, MB_SIN, MB_A00, MB_A01, MB_A10, MB_A11
	} mul_b_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;
	typedef enum logic [1:0] {SH_8, SH_14, SH_16} fin_sh_t;
	typedef enum logic [1:0] {FA_NONE, FA_VTX, FA_VTY} fin_add_t;
	typedef enum logic {FD_UX, FD_UY} fin_dst_t;

	typedef struct packed {
		mul_a_t   mul_a;
		mul_b_t   mul_b;
		acc_op_t  acc_op;
		logic     fin_en;
		fin_dst_t fin_dst;
		fin_sh_t  fin_sh;
		fin_add_t fin_add;
		logic     trans_en;
		logic     last;
	} avt_uop_t;

	typedef struct packed {
		logic     capture;
		avt_uop_t uop;
		logic     tick_rev;
		logic     tick_add;
		logic     out_load;
		logic     out_kind;
	} avt_cmd_t;

	function automatic avt_uop_t avt_uop(input logic [STEP_W-1:0] step);
		avt_uop_t u;
		u = '0;
		case (step)
			STEP_W'(0): begin
				u.mul_a = MA_IN_X; u.mul_b = MB_SCX;
			end
			STEP_W'(1): begin
				u.mul_a = MA_IN_Y; u.mul_b = MB_SCY; u.acc_op = ACC_LOAD;
			end
			STEP_W'(2): begin
				u.acc_op = ACC_LOAD;
				u.fin_en = 1'b1; u.fin_sh = SH_8; u.fin_dst = FD_UX;
			end
			STEP_W'(3): begin
				u.fin_en = 1'b1; u.fin_sh = SH_8; u.fin_dst = FD_UY;
			end
			STEP_W'(4): begin
				u.mul_a = MA_UX; u.mul_b = MB_COS;
			end
			STEP_W'(5): begin
				u.mul_a = MA_UY; u.mul_b = MB_SIN; u.acc_op = ACC_LOAD;
			end
			STEP_W'(6): begin
				u.mul_a = MA_UX; u.mul_b = MB_SIN; u.acc_op = ACC_SUB;
			end
			STEP_W'(7): begin
				u.mul_a = MA_UY; u.mul_b = MB_COS; u.acc_op = ACC_LOAD;
				u.fin_en = 1'b1; u.fin_sh = SH_14; u.fin_dst = FD_UX;
			end
			STEP_W'(8): begin
				u.acc_op = ACC_ADD;
			end
			STEP_W'(9): begin
				u.fin_en = 1'b1; u.fin_sh = SH_14; u.fin_dst = FD_UY;
			end
			STEP_W'(10): begin
				u.trans_en = 1'b1;
			end
			STEP_W'(11): begin
				u.mul_a = MA_UX; u.mul_b = MB_A00;
			end
			STEP_W'(12): begin
				u.mul_a = MA_UY; u.mul_b = MB_A10; u.acc_op = ACC_LOAD;
			end
			STEP_W'(13): begin
				u.mul_a = MA_UX; u.mul_b = MB_A01; u.acc_op = ACC_ADD;
			end
			STEP_W'(14): begin
				u.mul_a = MA_UY; u.mul_b = MB_A11; u.acc_op = ACC_LOAD;
				u.fin_en = 1'b1; u.fin_sh = SH_16; u.fin_dst = FD_UX;
				u.fin_add = FA_VTX;
			end
			STEP_W'(15): begin
				u.acc_op = ACC_ADD;
			end
			STEP_W'(16): begin
				u.fin_en = 1'b1; u.fin_sh = SH_16; u.fin_dst = FD_UY;
				u.fin_add = FA_VTY; u.last = 1'b1;
			end
			default: begin
				u = '0;
			end
		endcase
		return u;
	endfunction

endpackage

// File: src/avt_ctrl.sv
module avt_ctrl import avt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  avt_kind_t kind,
	input  logic      m_tready,
	output logic      s_tready,
	output logic      m_tvalid,
	output avt_cmd_t  cmd
);

	avt_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q;
	avt_kind_t         kind_q;
	logic              out_valid_q;
	logic              accept;
	avt_uop_t          uop;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign uop      = avt_uop(step_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_VERTEX: state_d = ST_VTX;
						KIND_TICK:   state_d = ST_TICK_REV;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_VTX: begin
				if (uop.last) state_d = ST_DONE;
			end
			ST_TICK_REV: state_d = ST_TICK_ADD;
			ST_TICK_ADD: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.capture  = accept;
		cmd.out_kind = (kind_q == KIND_TICK);
		case (state_q)
			ST_VTX:      cmd.uop = uop;
			ST_TICK_REV: cmd.tick_rev = 1'b1;
			ST_TICK_ADD: cmd.tick_add = 1'b1;
			ST_DONE:     cmd.out_load = !out_valid_q || m_tready;
			default:     cmd.uop = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			kind_q      <= KIND_VERTEX;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
				kind_q <= kind;
			end else if (state_q == ST_VTX) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/avt_dp.sv
module avt_dp import avt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  avt_cmd_t    cmd,
	input  avt_kind_t   kind,
	input  logic [31:0] coord_x,
	input  logic [31:0] coord_y,
	input  logic [2:0]  view_index,
	input  logic [31:0] view_value,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic        out_kind
);

	logic signed [15:0] scale_x_q, scale_y_q, cos_q, sin_q;
	logic [31:0]        step_x_q, step_y_q;
	logic [30:0]        limit_x_q;
	logic [31:0]        pos_x_q, pos_y_q;
	logic               rev_q;
	logic [31:0]        view_q [VIEW_WORDS];

	logic [31:0]        in_x_q, in_y_q, ux_q, uy_q;
	logic signed [63:0] mul_s1;
	logic signed [65:0] acc_q;
	logic [31:0]        out_x_q, out_y_q;
	logic               out_kind_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic signed [65:0] prod_ext, rnd_sum, shifted, fin_sum, addend;
	logic [31:0]        fin_val;
	logic               flip, rev_new;

	function automatic logic [31:0] sat_66(input logic signed [65:0] v);
		logic [31:0] r;
		if (v[65:31] == '0 || v[65:31] == '1) r = v[31:0];
		else r = v[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return r;
	endfunction

	function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		logic [31:0] r;
		s = {a[31], a} + {b[31], b};
		if (s[32] == s[31]) r = s[31:0];
		else r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return r;
	endfunction

	function automatic logic [31:0] eff_step(input logic [31:0] s, input logic r);
		logic [31:0] n;
		n = (s == 32'h8000_0000) ? 32'h7FFF_FFFF : 32'd0 - s;
		return r ? n : s;
	endfunction

	always_comb begin
		case (cmd.uop.mul_a)
			MA_IN_X: mul_a = in_x_q;
			MA_IN_Y: mul_a = in_y_q;
			MA_UX:   mul_a = ux_q;
			MA_UY:   mul_a = uy_q;
			default: mul_a = in_x_q;
		endcase
		case (cmd.uop.mul_b)
			MB_SCX:  mul_b = 32'(scale_x_q);
			MB_SCY:  mul_b = 32'(scale_y_q);
			MB_COS:  mul_b = 32'(cos_q);
			MB_SIN:  mul_b = 32'(sin_q);
			MB_A00:  mul_b = view_q[VW_A00];
			MB_A01:  mul_b = view_q[VW_A01];
			MB_A10:  mul_b = view_q[VW_A10];
			MB_A11:  mul_b = view_q[VW_A11];
			default: mul_b = 32'(scale_x_q);
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign prod_ext = 66'(mul_s1);

	always_comb begin
		case (cmd.uop.fin_sh)
			SH_8: begin
				rnd_sum = acc_q + 66'sd128;
				shifted = rnd_sum >>> 8;
			end
			SH_14: begin
				rnd_sum = acc_q + 66'sd8192;
				shifted = rnd_sum >>> 14;
			end
			default: begin
				rnd_sum = acc_q + 66'sd32768;
				shifted = rnd_sum >>> 16;
			end
		endcase
		case (cmd.uop.fin_add)
			FA_VTX:  addend = 66'(signed'(view_q[VW_TX]));
			FA_VTY:  addend = 66'(signed'(view_q[VW_TY]));
			default: addend = '0;
		endcase
		fin_sum = shifted + addend;
		fin_val = sat_66(fin_sum);
	end

	assign flip    = pos_x_q[31] || (pos_x_q[30:0] > limit_x_q);
	assign rev_new = rev_q ^ flip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= RST_SCALE;
			scale_y_q <= RST_SCALE;
			cos_q     <= RST_COS;
			sin_q     <= RST_SIN;
			step_x_q  <= RST_STEP_X;
			step_y_q  <= RST_STEP_Y;
			limit_x_q <= RST_LIMIT_X;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCALE_X: scale_x_q <= cfg_data[15:0];
				CFG_SCALE_Y: scale_y_q <= cfg_data[15:0];
				CFG_COS:     cos_q     <= cfg_data[15:0];
				CFG_SIN:     sin_q     <= cfg_data[15:0];
				CFG_STEP_X:  step_x_q  <= cfg_data;
				CFG_STEP_Y:  step_y_q  <= cfg_data;
				CFG_LIMIT_X: limit_x_q <= cfg_data[30:0];
				default:     limit_x_q <= limit_x_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			rev_q   <= 1'b0;
			for (int i = 0; i < VIEW_WORDS; i++) begin
				view_q[i] <= (i == int'(VW_A00) || i == int'(VW_A11)) ? Q_ONE : '0;
			end
		end else begin
			if (cmd.capture && kind == KIND_PLACE) begin
				pos_x_q <= coord_x;
				pos_y_q <= coord_y;
				rev_q   <= 1'b0;
			end
			if (cmd.capture && kind == KIND_VIEW && view_index < 3'(VIEW_WORDS)) begin
				view_q[view_index] <= view_value;
			end
			if (cmd.tick_rev) begin
				rev_q <= rev_new;
			end
			if (cmd.tick_add) begin
				pos_x_q <= add_sat(pos_x_q, ux_q);
				pos_y_q <= add_sat(pos_y_q, uy_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		mul_s1 <= prod;
		if (cmd.capture) begin
			in_x_q <= coord_x;
			in_y_q <= coord_y;
		end
		case (cmd.uop.acc_op)
			ACC_LOAD: acc_q <= prod_ext;
			ACC_ADD:  acc_q <= acc_q + prod_ext;
			ACC_SUB:  acc_q <= acc_q - prod_ext;
			default:  acc_q <= acc_q;
		endcase
		if (cmd.uop.fin_en) begin
			if (cmd.uop.fin_dst == FD_UX) ux_q <= fin_val;
			else uy_q <= fin_val;
		end
		if (cmd.uop.trans_en) begin
			ux_q <= add_sat(ux_q, pos_x_q);
			uy_q <= add_sat(uy_q, pos_y_q);
		end
		if (cmd.tick_rev) begin
			ux_q <= eff_step(step_x_q, rev_new);
			uy_q <= eff_step(step_y_q, rev_new);
		end
		if (cmd.out_load) begin
			out_kind_q <= cmd.out_kind;
			out_x_q    <= cmd.out_kind ? pos_x_q : ux_q;
			out_y_q    <= cmd.out_kind ? pos_y_q : uy_q;
		end
	end

	assign out_x    = out_x_q;
	assign out_y    = out_y_q;
	assign out_kind = out_kind_q;

endmodule

// File: src/affine_vertex_transform_bounce_top.sv
// Affine vertex transform with a bouncing position.
// Input words arrive on s_tvalid/s_tready; s_tuser carries the item kind
// (vertex, tick, view word write, place position). Vertex and tick items
// each give one result word on m_tvalid/m_tready; view writes and place
// items give none.
// Configuration registers are written through cfg_we/cfg_index/cfg_data, with no
// read-back; the user must write them while the block is idle (not enforced).
// A vertex runs 17 steps through one shared 32x32 multiplier and one
// accumulator (scale, rotate, translate, view map), then loads the output
// register; the next word is taken only after that output load. A tick
// passes through a reverse check, an add and an output load. View and place
// words complete in the accepting cycle, so they can follow back to back.
// The output register holds a result until taken; a finished item waits in
// its last state only while the previous result is still held, so the next
// word is accepted while a result waits.
// Reset restores the register defaults, zeroes the position, clears the
// reversal flag and loads the identity view matrix.
module affine_vertex_transform_bounce_top import avt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // coord_x, coord_y, view_index, view_value, zero pad
	input  logic [1:0]   s_tuser,   // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // out_x, out_y
	output logic         m_tuser,   // result_kind
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	avt_cmd_t  cmd;
	avt_kind_t kind;
	logic [31:0] out_x, out_y;

	assign kind = avt_kind_t'(s_tuser);

	avt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.kind     (kind),
		.m_tready (m_tready),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	avt_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.kind       (kind),
		.coord_x    (s_tdata[31:0]),
		.coord_y    (s_tdata[63:32]),
		.view_index (s_tdata[66:64]),
		.view_value (s_tdata[98:67]),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_kind   (m_tuser)
	);

	assign m_tdata = {out_y, out_x};

endmodule

// File: src/avt_chk.sv
module avt_chk import avt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_quick_items: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == KIND_VIEW || s_tuser == KIND_PLACE)
		|=> s_tready)
		else $error("view or place word did not complete at once");

	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == KIND_VERTEX || s_tuser == KIND_TICK)
		|=> !s_tready)
		else $error("new word taken while vertex or tick in progress");

endmodule

bind affine_vertex_transform_bounce_top avt_chk u_avt_chk (.*);
